FILE: design/tkvl_pkg.sv
// Shared types and constants of the top-k volume list.
`default_nettype none

package tkvl_pkg;

    localparam int VOL_W    = 24;
    localparam int NODE_W   = 24;
    localparam int LINK_W   = 24;
    localparam int PERIOD_W = 8;
    localparam int LANES_W  = 4;
    localparam int IDX_W    = 7;
    localparam int KIND_W   = 2;
    localparam int MODE_W   = 2;

    localparam int LIST_SIZE_DEF = 128;

    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 32;

    // Register indexes of the configuration port.
    localparam logic REG_MODE    = 1'b0;
    localparam logic REG_MIN_VOL = 1'b1;

    // Request kinds.
    localparam logic [KIND_W-1:0] KIND_SAMPLE = 2'd0;
    localparam logic [KIND_W-1:0] KIND_CLOSE  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_READ   = 2'd2;
    localparam logic [KIND_W-1:0] KIND_CLEAR  = 2'd3;

    // Operating modes; the unused code behaves as MODE_PEAK.
    localparam logic [MODE_W-1:0] MODE_EVERY = 2'd0;
    localparam logic [MODE_W-1:0] MODE_PEAK  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_LANE  = 2'd2;

    typedef struct packed {
        logic [KIND_W-1:0]   kind;
        logic [LINK_W-1:0]   link_id;
        logic [NODE_W-1:0]   from_node;
        logic [NODE_W-1:0]   to_node;
        logic [PERIOD_W-1:0] period;
        logic [VOL_W-1:0]    volume;
        logic [LANES_W-1:0]  lanes;
        logic [IDX_W-1:0]    read_index;
    } t_req;

    typedef struct packed {
        logic                entry_valid;
        logic [LINK_W-1:0]   out_link;
        logic [NODE_W-1:0]   out_from;
        logic [NODE_W-1:0]   out_to;
        logic [PERIOD_W-1:0] out_period;
        logic [VOL_W-1:0]    out_volume;
    } t_result;

    typedef struct packed {
        logic [LINK_W-1:0]   link;
        logic [NODE_W-1:0]   from_node;
        logic [NODE_W-1:0]   to_node;
        logic [PERIOD_W-1:0] period;
        logic [VOL_W-1:0]    volume;
    } t_entry;

endpackage

`default_nettype wire

FILE: design/tkvl_div.sv
// Serial restoring divider: volume divided by lane count, one quotient bit per cycle.
`default_nettype none

module tkvl_div (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_start,
    input  wire logic [tkvl_pkg::VOL_W-1:0]    i_dividend,
    input  wire logic [tkvl_pkg::LANES_W-1:0]  i_divisor,
    output logic                               o_done,
    output logic [tkvl_pkg::VOL_W-1:0]         o_quotient
);

    localparam int CNT_W = $clog2(tkvl_pkg::VOL_W);
    localparam int LW    = tkvl_pkg::LANES_W;

    logic                            r_busy;
    logic                            r_done;
    logic [CNT_W-1:0]                r_cnt;
    logic [LW-1:0]                   r_rem;
    logic [LW-1:0]                   r_div;
    logic [tkvl_pkg::VOL_W-1:0]      r_q;

    logic [LW:0] rem_sh;
    logic        ge;
    logic [LW:0] rem_sub;

    always_comb begin
        rem_sh  = {r_rem, r_q[tkvl_pkg::VOL_W-1]};
        ge      = rem_sh >= {1'b0, r_div};
        rem_sub = rem_sh - {1'b0, r_div};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(tkvl_pkg::VOL_W - 1);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q   <= i_dividend;
            r_div <= i_divisor;
            r_rem <= '0;
        end else if (r_busy) begin
            // The remainder stays below the divisor, so its low bits are enough.
            r_rem <= ge ? rem_sub[LW-1:0] : rem_sh[LW-1:0];
            r_q   <= {r_q[tkvl_pkg::VOL_W-2:0], ge};
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_q;

endmodule

`default_nettype wire

FILE: design/top_k_volume_list_core.sv
// Top level of the top-k volume list: request decode, list memory and insertion sequencer.
//
// Usage: a request on i_req is taken at a clock edge where start is high and
// busy is low. Kinds: period sample, close direction, read entry, clear list.
// Only a read entry request gives a result: o_valid is high for exactly one
// cycle with o_result, in the cycle after the request was taken. The receiver
// cannot hold results off, and the block never needs it to.
// Per request: a sample that changes only the peak, or is dropped, and a
// clear leave busy low. A read holds busy high while its result is shown. A
// sample in lane mode with more than one lane runs the serial divider. A
// request that inserts into the list walks the list memory from the tail
// upward, one entry per cycle, moving each smaller entry down by one, until an
// entry not smaller than the new one or the head is reached. The single list
// memory with its registered read port sets the pace of this walk.
// Reset empties the list through a fill count, so no clearing pass is needed;
// registers go to mode 0 and minimum volume 0, and the peak is cleared.
// The APB port holds the mode at address 0 and the minimum volume at 4;
// write it only while busy is low.
`default_nettype none

module top_k_volume_list_core #(
    parameter int LIST_SIZE = tkvl_pkg::LIST_SIZE_DEF
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                start,
    output logic                                     busy,
    input  wire tkvl_pkg::t_req                      i_req,
    output logic                                     o_valid,
    output tkvl_pkg::t_result                        o_result,
    input  wire logic                                psel,
    input  wire logic                                penable,
    input  wire logic                                pwrite,
    input  wire logic [tkvl_pkg::CFG_ADDR_W-1:0]     paddr,
    input  wire logic [tkvl_pkg::CFG_DATA_W-1:0]     pwdata,
    output logic [tkvl_pkg::CFG_DATA_W-1:0]          prdata,
    output logic                                     pready
);

    localparam int AW = (LIST_SIZE > 1) ? $clog2(LIST_SIZE) : 1;
    localparam int CW = $clog2(LIST_SIZE + 1);

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_DIV  = 5'b00010,
        ST_READ = 5'b00100,
        ST_INS  = 5'b01000,
        ST_PUT  = 5'b10000
    } t_state;

    // List memory.
    tkvl_pkg::t_entry r_mem [LIST_SIZE];
    tkvl_pkg::t_entry r_rdata;

    logic             mem_we;
    logic [AW-1:0]    mem_waddr;
    tkvl_pkg::t_entry mem_wdata;
    logic             mem_re;
    logic [AW-1:0]    mem_raddr;

    // Control and state registers.
    t_state                            r_state, n_state;
    logic [CW-1:0]                     r_count, n_count;
    logic [tkvl_pkg::VOL_W-1:0]        r_floor, n_floor;
    logic [AW-1:0]                     r_pos, n_pos;
    tkvl_pkg::t_entry                  r_cand, n_cand;
    tkvl_pkg::t_req                    r_req;
    logic                              r_hit, n_hit;
    logic [tkvl_pkg::MODE_W-1:0]       r_mode;
    logic [tkvl_pkg::VOL_W-1:0]        r_min_vol;
    logic [tkvl_pkg::VOL_W-1:0]        r_pk_vol, n_pk_vol;
    logic [tkvl_pkg::PERIOD_W-1:0]     r_pk_period, n_pk_period;
    logic [tkvl_pkg::NODE_W-1:0]       r_pk_from, n_pk_from;
    logic [tkvl_pkg::NODE_W-1:0]       r_pk_to, n_pk_to;

    logic                              accept;
    logic                              full;
    logic [AW-1:0]                     last;
    logic                              off_en;
    tkvl_pkg::t_entry                  off_entry;
    logic                              div_start;
    logic                              div_done;
    logic [tkvl_pkg::VOL_W-1:0]        div_q;
    logic                              cfg_wr;

    tkvl_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (i_req.volume),
        .i_divisor  (i_req.lanes),
        .o_done     (div_done),
        .o_quotient (div_q)
    );

    assign busy   = (r_state != ST_IDLE);
    assign accept = start && !busy;
    assign full   = (r_count == CW'(LIST_SIZE));
    assign last   = full ? AW'(LIST_SIZE - 1) : AW'(r_count);

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_floor     = r_floor;
        n_pos       = r_pos;
        n_cand      = r_cand;
        n_hit       = r_hit;
        n_pk_vol    = r_pk_vol;
        n_pk_period = r_pk_period;
        n_pk_from   = r_pk_from;
        n_pk_to     = r_pk_to;
        mem_we      = 1'b0;
        mem_waddr   = r_pos;
        mem_wdata   = r_cand;
        mem_re      = 1'b0;
        mem_raddr   = '0;
        off_en      = 1'b0;
        off_entry   = '0;
        div_start   = 1'b0;

        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    case (i_req.kind)
                        tkvl_pkg::KIND_SAMPLE: begin
                            if (i_req.volume >= r_min_vol) begin
                                if (r_mode == tkvl_pkg::MODE_EVERY) begin
                                    off_en    = 1'b1;
                                    off_entry = '{link: i_req.link_id,
                                                  from_node: i_req.from_node,
                                                  to_node: i_req.to_node,
                                                  period: i_req.period,
                                                  volume: i_req.volume};
                                end else if (r_mode == tkvl_pkg::MODE_LANE
                                             && i_req.lanes > 4'd1) begin
                                    div_start = 1'b1;
                                    n_state   = ST_DIV;
                                end else if (i_req.volume > r_pk_vol) begin
                                    n_pk_vol    = i_req.volume;
                                    n_pk_period = i_req.period;
                                    n_pk_from   = i_req.from_node;
                                    n_pk_to     = i_req.to_node;
                                end
                            end
                        end
                        tkvl_pkg::KIND_CLOSE: begin
                            off_en      = (r_pk_vol != '0);
                            off_entry   = '{link: i_req.link_id,
                                            from_node: r_pk_from,
                                            to_node: r_pk_to,
                                            period: r_pk_period,
                                            volume: r_pk_vol};
                            n_pk_vol    = '0;
                            n_pk_period = '0;
                            n_pk_from   = '0;
                            n_pk_to     = '0;
                        end
                        tkvl_pkg::KIND_READ: begin
                            mem_re    = 1'b1;
                            mem_raddr = AW'(i_req.read_index);
                            n_hit     = 32'(i_req.read_index) < 32'(r_count);
                            n_state   = ST_READ;
                        end
                        tkvl_pkg::KIND_CLEAR: begin
                            n_count = '0;
                            n_floor = '0;
                        end
                        default: ;
                    endcase

                    // A zero volume never enters; a full list takes only what beats its tail.
                    if (off_en && off_entry.volume != '0
                        && (!full || off_entry.volume > r_floor)) begin
                        n_cand  = off_entry;
                        n_count = full ? r_count : r_count + 1'b1;
                        n_pos   = last;
                        if (last == '0) begin
                            n_state = ST_PUT;
                        end else begin
                            mem_re    = 1'b1;
                            mem_raddr = last - 1'b1;
                            n_state   = ST_INS;
                        end
                    end
                end
            end
            ST_DIV: begin
                if (div_done) begin
                    if (div_q > r_pk_vol) begin
                        n_pk_vol    = div_q;
                        n_pk_period = r_req.period;
                        n_pk_from   = r_req.from_node;
                        n_pk_to     = r_req.to_node;
                    end
                    n_state = ST_IDLE;
                end
            end
            ST_READ: begin
                n_state = ST_IDLE;
            end
            ST_INS: begin
                // Entries of equal volume stay ahead of the new one.
                mem_we    = 1'b1;
                mem_waddr = r_pos;
                if (r_rdata.volume < r_cand.volume) begin
                    mem_wdata = r_rdata;
                    n_pos     = r_pos - 1'b1;
                    if (r_pos == AW'(1)) begin
                        n_state = ST_PUT;
                    end else begin
                        mem_re    = 1'b1;
                        mem_raddr = r_pos - AW'(2);
                    end
                end else begin
                    mem_wdata = r_cand;
                    n_state   = ST_IDLE;
                end
            end
            ST_PUT: begin
                mem_we    = 1'b1;
                mem_waddr = r_pos;
                mem_wdata = r_cand;
                n_state   = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase

        if (mem_we && mem_waddr == AW'(LIST_SIZE - 1)) begin
            n_floor = mem_wdata.volume;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            r_rdata <= r_mem[mem_raddr];
        end
    end

    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_count     <= '0;
            r_floor     <= '0;
            r_mode      <= tkvl_pkg::MODE_EVERY;
            r_min_vol   <= '0;
            r_pk_vol    <= '0;
            r_pk_period <= '0;
            r_pk_from   <= '0;
            r_pk_to     <= '0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_floor     <= n_floor;
            r_pk_vol    <= n_pk_vol;
            r_pk_period <= n_pk_period;
            r_pk_from   <= n_pk_from;
            r_pk_to     <= n_pk_to;
            if (cfg_wr) begin
                case (paddr[2])
                    tkvl_pkg::REG_MODE:    r_mode    <= pwdata[tkvl_pkg::MODE_W-1:0];
                    tkvl_pkg::REG_MIN_VOL: r_min_vol <= pwdata[tkvl_pkg::VOL_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_pos  <= n_pos;
        r_cand <= n_cand;
        r_hit  <= n_hit;
        if (accept) begin
            r_req <= i_req;
        end
    end

    always_comb begin
        case (paddr[2])
            tkvl_pkg::REG_MODE:    prdata = tkvl_pkg::CFG_DATA_W'(r_mode);
            tkvl_pkg::REG_MIN_VOL: prdata = tkvl_pkg::CFG_DATA_W'(r_min_vol);
            default:               prdata = '0;
        endcase
    end

    assign pready = 1'b1;

    assign o_valid = (r_state == ST_READ);

    always_comb begin
        if (r_hit) begin
            o_result = '{entry_valid: 1'b1,
                         out_link: r_rdata.link,
                         out_from: r_rdata.from_node,
                         out_to: r_rdata.to_node,
                         out_period: r_rdata.period,
                         out_volume: r_rdata.volume};
        end else begin
            o_result = '0;
        end
    end

    a_read_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_req.kind == tkvl_pkg::KIND_READ) |=> o_valid)
        else $error("read request gave no result in the next cycle");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_count) <= LIST_SIZE)
        else $error("fill count exceeds list size");

    a_result_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> busy)
        else $error("result shown while a new request could be taken");

    a_ins_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_INS) |-> (r_pos != '0))
        else $error("insertion walk reached the head without a final write");

    a_hit_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_result.entry_valid) |-> (o_result.out_volume != '0))
        else $error("valid list entry read with zero volume");

endmodule

`default_nettype wire
